>>> src/bdpe_pkg.sv
// Package for the button debounce and press event block.
// Holds the shared types, event codes and reset constants; depends on nothing.
`default_nettype none

package bdpe_pkg;

    localparam int NUM_BUTTONS_DEF = 4;
    localparam int RAW_WIDTH       = 4;
    localparam int MASK_WIDTH      = 4;
    localparam int INDEX_WIDTH     = 2;
    localparam int TIME_WIDTH      = 32;
    localparam int CFG_WIDTH       = 16;

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_CLICK = 2'd1,
        EV_LONG  = 2'd2,
        EV_HOLD  = 2'd3
    } event_code_t;

    typedef enum logic [0:0] {
        CFG_DEBOUNCE   = 1'b0,
        CFG_LONG_PRESS = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0] {
        ACT_SCAN  = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

    typedef struct packed {
        logic                  accept;
        action_t               action;
        logic [TIME_WIDTH-1:0] now_ms;
        logic [CFG_WIDTH-1:0]  debounce_ms;
        logic [CFG_WIDTH-1:0]  long_press_ms;
    } lane_cmd_t;

    typedef struct packed {
        event_code_t event_code;
        logic        stable_next;
    } lane_status_t;

endpackage

`default_nettype wire

>>> src/bdpe_lane.sv
// One button lane: raw level tracking, debounce and press event state.
// Depends on bdpe_pkg for the command, status and event code types.
`default_nettype none

module bdpe_lane (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire bdpe_pkg::lane_cmd_t  cmd,
    input  wire logic                 lvl,
    input  wire logic                 sel,
    output bdpe_pkg::lane_status_t    status
);

    logic                            last_raw_reg, last_raw_next;
    logic                            stable_reg, stable_next;
    logic [bdpe_pkg::TIME_WIDTH-1:0] last_change_reg, last_change_next;
    logic [bdpe_pkg::TIME_WIDTH-1:0] press_start_reg, press_start_next;
    logic                            long_rep_reg, long_rep_next;
    logic                            pending_reg, pending_next;

    logic [bdpe_pkg::TIME_WIDTH-1:0] since_change;
    logic [bdpe_pkg::TIME_WIDTH-1:0] since_press;
    logic                            steady;
    logic                            long_due;
    bdpe_pkg::event_code_t           event_code;

    assign since_change = cmd.now_ms - last_change_reg;
    assign since_press  = cmd.now_ms - press_start_reg;
    assign steady   = since_change >
        {{(bdpe_pkg::TIME_WIDTH-bdpe_pkg::CFG_WIDTH){1'b0}}, cmd.debounce_ms};
    assign long_due = since_press >=
        {{(bdpe_pkg::TIME_WIDTH-bdpe_pkg::CFG_WIDTH){1'b0}}, cmd.long_press_ms};

    always_comb begin
        last_raw_next    = last_raw_reg;
        stable_next      = stable_reg;
        last_change_next = last_change_reg;
        press_start_next = press_start_reg;
        long_rep_next    = long_rep_reg;
        pending_next     = pending_reg;
        event_code       = bdpe_pkg::EV_NONE;
        case (cmd.action)
            bdpe_pkg::ACT_SCAN: begin
                if (lvl != last_raw_reg) begin
                    // A change restarts the debounce time, so it cannot be accepted now.
                    last_raw_next    = lvl;
                    last_change_next = cmd.now_ms;
                end else if (steady && (lvl != stable_reg)) begin
                    stable_next = lvl;
                    if (!lvl) begin
                        press_start_next = cmd.now_ms;
                        long_rep_next    = 1'b0;
                        pending_next     = 1'b1;
                    end
                end
            end
            bdpe_pkg::ACT_QUERY: begin
                if (sel) begin
                    if (!stable_reg) begin
                        if (!long_rep_reg && long_due) begin
                            long_rep_next = 1'b1;
                            event_code    = bdpe_pkg::EV_LONG;
                        end else if (long_rep_reg) begin
                            event_code = bdpe_pkg::EV_HOLD;
                        end
                    end else if (pending_reg) begin
                        pending_next  = 1'b0;
                        long_rep_next = 1'b0;
                        if (!long_rep_reg) begin
                            event_code = bdpe_pkg::EV_CLICK;
                        end
                    end
                end
            end
            default: begin
                event_code = bdpe_pkg::EV_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_raw_reg    <= 1'b1;
            stable_reg      <= 1'b1;
            last_change_reg <= '0;
            press_start_reg <= '0;
            long_rep_reg    <= 1'b0;
            pending_reg     <= 1'b0;
        end else if (cmd.accept) begin
            last_raw_reg    <= last_raw_next;
            stable_reg      <= stable_next;
            last_change_reg <= last_change_next;
            press_start_reg <= press_start_next;
            long_rep_reg    <= long_rep_next;
            pending_reg     <= pending_next;
        end
    end

    assign status.event_code  = event_code;
    assign status.stable_next = stable_next;

endmodule

`default_nettype wire

>>> src/bdpe_merge.sv
// Merging stage: combines the lane results into one event code and the pressed mask.
// Depends on bdpe_pkg for the lane status and event code types.
`default_nettype none

module bdpe_merge #(
    parameter int NUM_BUTTONS = bdpe_pkg::NUM_BUTTONS_DEF
) (
    input  wire bdpe_pkg::lane_status_t [NUM_BUTTONS-1:0] status,
    output bdpe_pkg::event_code_t                         event_code,
    output logic [bdpe_pkg::MASK_WIDTH-1:0]               pressed_mask
);

    localparam int MASK_LANES =
        (NUM_BUTTONS < bdpe_pkg::MASK_WIDTH) ? NUM_BUTTONS : bdpe_pkg::MASK_WIDTH;

    logic [1:0] code_or;

    // At most one lane is selected by a query, so the others report no event.
    always_comb begin
        code_or = 2'd0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            code_or = code_or | status[i].event_code;
        end
        pressed_mask = '0;
        for (int i = 0; i < MASK_LANES; i++) begin
            pressed_mask[i] = !status[i].stable_next;
        end
    end

    assign event_code = bdpe_pkg::event_code_t'(code_or);

endmodule

`default_nettype wire

>>> src/button_debounce_press_events.sv
// Top level of the button debounce and press event block.
// Depends on bdpe_pkg, bdpe_lane and bdpe_merge.
`default_nettype none

// Debounces NUM_BUTTONS active-low buttons and reports press events. Each
// button lane updates its registered state in the cycle the item is accepted,
// the merging stage feeds an output register, and a new item is accepted in
// every cycle in which that register is empty or its result is taken, for a
// sustained rate of one item per cycle. Buttons numbered four or higher read
// as released and have no pressed mask bit; a query index with no lane yields
// no event. Configuration writes take effect at once and are meant for idle
// times.
module button_debounce_press_events #(
    parameter int NUM_BUTTONS = bdpe_pkg::NUM_BUTTONS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic                               cfg_index,
    input  wire logic [bdpe_pkg::CFG_WIDTH-1:0]     cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_action,
    input  wire logic [bdpe_pkg::TIME_WIDTH-1:0]    s_now_ms,
    input  wire logic [bdpe_pkg::RAW_WIDTH-1:0]     s_raw_levels,
    input  wire logic [bdpe_pkg::INDEX_WIDTH-1:0]   s_button_index,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [1:0]                              m_event_code,
    output logic [bdpe_pkg::MASK_WIDTH-1:0]         m_pressed_mask
);

    logic [bdpe_pkg::CFG_WIDTH-1:0]  debounce_reg;
    logic [bdpe_pkg::CFG_WIDTH-1:0]  long_press_reg;
    logic                            m_valid_reg;
    bdpe_pkg::event_code_t           m_event_code_reg;
    logic [bdpe_pkg::MASK_WIDTH-1:0] m_pressed_mask_reg;

    logic                                        s_accept;
    bdpe_pkg::lane_cmd_t                         cmd;
    bdpe_pkg::lane_status_t [NUM_BUTTONS-1:0]    status;
    bdpe_pkg::event_code_t                       merged_code;
    logic [bdpe_pkg::MASK_WIDTH-1:0]             merged_mask;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= bdpe_pkg::DEBOUNCE_RESET;
            long_press_reg <= bdpe_pkg::LONG_PRESS_RESET;
        end else if (cfg_we) begin
            case (bdpe_pkg::cfg_index_t'(cfg_index))
                bdpe_pkg::CFG_DEBOUNCE:   debounce_reg   <= cfg_wdata;
                bdpe_pkg::CFG_LONG_PRESS: long_press_reg <= cfg_wdata;
                default: begin
                    debounce_reg <= debounce_reg;
                end
            endcase
        end
    end

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    assign cmd.accept        = s_accept;
    assign cmd.action        = bdpe_pkg::action_t'(s_action);
    assign cmd.now_ms        = s_now_ms;
    assign cmd.debounce_ms   = debounce_reg;
    assign cmd.long_press_ms = long_press_reg;

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        logic lane_lvl;
        logic lane_sel;
        if (g < bdpe_pkg::RAW_WIDTH) begin : g_pin
            assign lane_lvl = s_raw_levels[g];
            assign lane_sel = (s_button_index == (bdpe_pkg::INDEX_WIDTH)'(g));
        end else begin : g_nopin
            assign lane_lvl = 1'b1;
            assign lane_sel = 1'b0;
        end
        bdpe_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd),
            .lvl     (lane_lvl),
            .sel     (lane_sel),
            .status  (status[g])
        );
    end

    bdpe_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .status       (status),
        .event_code   (merged_code),
        .pressed_mask (merged_mask)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_event_code_reg   <= merged_code;
            m_pressed_mask_reg <= merged_mask;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_event_code   = m_event_code_reg;
    assign m_pressed_mask = m_pressed_mask_reg;

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid)
        else $error("Accepted transaction produced no result.");

    a_scan_no_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !s_action) |=> (m_event_code == bdpe_pkg::EV_NONE))
        else $error("Scan transaction returned an event.");

    a_mask_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_pressed_mask >> NUM_BUTTONS) == '0))
        else $error("Pressed mask shows a button that has no lane.");

endmodule

`default_nettype wire

>>> tb/button_debounce_press_events_tb.sv
`timescale 1ns / 100ps
// Testbench for button_debounce_press_events: directed press, hold and click
// scenarios, then random scan/query traffic under several debounce and long-press
// settings. Depends on bdpe_pkg and the block's RTL.

module button_debounce_press_events_tb;

    class press_event_scoreboard;
        typedef struct packed {
            bdpe_pkg::event_code_t code;
            logic [3:0]            mask;
        } press_result_t;

        logic [15:0]   debounce_ms;
        logic [15:0]   long_press_ms;
        logic [3:0]    raw_seen;
        logic [3:0]    level_stable;
        logic [31:0]   change_ms [4];
        logic [31:0]   press_ms [4];
        logic [3:0]    long_seen;
        logic [3:0]    click_pending;
        press_result_t expected_events [$];
        int            mismatches;

        function new();
            debounce_ms   = bdpe_pkg::DEBOUNCE_RESET;
            long_press_ms = bdpe_pkg::LONG_PRESS_RESET;
            raw_seen      = 4'hF;
            level_stable  = 4'hF;
            long_seen     = 4'h0;
            click_pending = 4'h0;
            for (int i = 0; i < 4; i++) begin
                change_ms[i] = 32'd0;
                press_ms[i]  = 32'd0;
            end
            mismatches = 0;
        endfunction

        function void set_config(bdpe_pkg::cfg_index_t idx, logic [15:0] value);
            if (idx == bdpe_pkg::CFG_DEBOUNCE) begin
                debounce_ms = value;
            end else begin
                long_press_ms = value;
            end
        endfunction

        function int pending_count();
            return expected_events.size();
        endfunction

        function void note_item(bdpe_pkg::action_t act, logic [31:0] now, logic [3:0] raw,
                                logic [1:0] idx);
            logic [31:0]   elapsed;
            press_result_t res;
            res.code = bdpe_pkg::EV_NONE;
            if (act == bdpe_pkg::ACT_SCAN) begin
                for (int i = 0; i < 4; i++) begin
                    if (raw[i] != raw_seen[i]) begin
                        change_ms[i] = now;
                        raw_seen[i]  = raw[i];
                    end
                    elapsed = now - change_ms[i];
                    if (elapsed > {16'd0, debounce_ms} && raw[i] != level_stable[i]) begin
                        level_stable[i] = raw[i];
                        if (raw[i] == 1'b0) begin
                            press_ms[i]      = now;
                            long_seen[i]     = 1'b0;
                            click_pending[i] = 1'b1;
                        end
                    end
                end
            end else if (level_stable[idx] == 1'b0) begin
                elapsed = now - press_ms[idx];
                if (!long_seen[idx] && elapsed >= {16'd0, long_press_ms}) begin
                    long_seen[idx] = 1'b1;
                    res.code = bdpe_pkg::EV_LONG;
                end else if (long_seen[idx]) begin
                    res.code = bdpe_pkg::EV_HOLD;
                end
            end else if (click_pending[idx]) begin
                res.code = long_seen[idx] ? bdpe_pkg::EV_NONE : bdpe_pkg::EV_CLICK;
                click_pending[idx] = 1'b0;
                long_seen[idx]     = 1'b0;
            end
            res.mask = ~level_stable;
            expected_events.push_back(res);
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 20) begin
                $display("%0t: %s", $time, what);
            end
        endtask

        task check_result(logic [1:0] got_code, logic [3:0] got_mask);
            press_result_t exp;
            if (expected_events.size() == 0) begin
                report("result transaction with nothing expected");
                return;
            end
            exp = expected_events.pop_front();
            if (got_code !== exp.code) begin
                report($sformatf("event_code got %0d, expected %0d", got_code, exp.code));
            end
            if (got_mask !== exp.mask) begin
                report($sformatf("pressed_mask got %h, expected %h", got_mask, exp.mask));
            end
        endtask

        task check_leftover();
            if (expected_events.size() != 0) begin
                report($sformatf("%0d results never arrived", expected_events.size()));
            end
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_action = 1'b0;
    logic [31:0] s_now_ms = 32'd0;
    logic [3:0]  s_raw_levels = 4'hF;
    logic [1:0]  s_button_index = 2'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_event_code;
    logic [3:0]  m_pressed_mask;

    logic        idle_on = 1'b1;
    logic        long_stall_req = 1'b0;
    logic        long_stall_done = 1'b0;
    int          stall_left = 0;
    logic [31:0] sim_ms = 32'd0;
    logic [3:0]  pin_levels = 4'hF;

    press_event_scoreboard sb;

    button_debounce_press_events u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_now_ms       (s_now_ms),
        .s_raw_levels   (s_raw_levels),
        .s_button_index (s_button_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_code   (m_event_code),
        .m_pressed_mask (m_pressed_mask)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (long_stall_req && !long_stall_done) begin
            long_stall_done <= 1'b1;
            stall_left      <= 150;
            m_ready         <= 1'b0;
        end else if (idle_on) begin
            m_ready <= ($urandom_range(0, 99) >= 28);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_item(bdpe_pkg::action_t'(s_action), s_now_ms, s_raw_levels,
                             s_button_index);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_event_code, m_pressed_mask);
            end
        end
    end

    task automatic send_item(bdpe_pkg::action_t act, logic [31:0] now, logic [3:0] raw,
                             logic [1:0] idx);
        if (idle_on) begin
            while ($urandom_range(0, 99) < 28) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid        <= 1'b1;
        s_action       <= act;
        s_now_ms       <= now;
        s_raw_levels   <= raw;
        s_button_index <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_count() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_config(logic [15:0] deb, logic [15:0] lp);
        cfg_we    <= 1'b1;
        cfg_index <= bdpe_pkg::CFG_DEBOUNCE;
        cfg_wdata <= deb;
        @(posedge aclk);
        sb.set_config(bdpe_pkg::CFG_DEBOUNCE, deb);
        cfg_index <= bdpe_pkg::CFG_LONG_PRESS;
        cfg_wdata <= lp;
        @(posedge aclk);
        sb.set_config(bdpe_pkg::CFG_LONG_PRESS, lp);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_random(int count);
        int unsigned deb;
        int unsigned lp;
        int unsigned pick;
        int unsigned bit_sel;
        logic [3:0]  raw;
        deb = sb.debounce_ms;
        lp  = sb.long_press_ms;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                sim_ms = sim_ms + $urandom_range(0, deb / 8 + 3);
            end else if (pick < 95) begin
                sim_ms = sim_ms + $urandom_range(deb / 2, deb + lp / 2 + 5);
            end else begin
                sim_ms = $urandom;
            end
            if ($urandom_range(0, 99) < 35) begin
                send_item(bdpe_pkg::ACT_QUERY, sim_ms, 4'($urandom),
                          2'($urandom_range(0, 3)));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    bit_sel = $urandom_range(0, 3);
                    pin_levels[bit_sel] = ~pin_levels[bit_sel];
                end
                raw = (pick >= 95) ? 4'($urandom) : pin_levels;
                send_item(bdpe_pkg::ACT_SCAN, sim_ms, raw, 2'($urandom_range(0, 3)));
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(bdpe_pkg::ACT_SCAN, 32'd0, 4'hF, 2'd3);
        send_item(bdpe_pkg::ACT_QUERY, 32'd0, 4'h0, 2'd0);
        send_item(bdpe_pkg::ACT_QUERY, 32'd0, 4'hF, 2'd3);
        send_item(bdpe_pkg::ACT_SCAN, 32'd10, 4'b1110, 2'd0);
        send_item(bdpe_pkg::ACT_SCAN, 32'd60, 4'b1110, 2'd0);
        send_item(bdpe_pkg::ACT_SCAN, 32'd61, 4'b1110, 2'd0);
        send_item(bdpe_pkg::ACT_QUERY, 32'd1060, 4'h0, 2'd0);
        send_item(bdpe_pkg::ACT_QUERY, 32'd1061, 4'h0, 2'd0);
        send_item(bdpe_pkg::ACT_QUERY, 32'd1070, 4'h0, 2'd0);
        send_item(bdpe_pkg::ACT_SCAN, 32'd1100, 4'b1111, 2'd0);
        send_item(bdpe_pkg::ACT_SCAN, 32'd1151, 4'b1111, 2'd0);
        send_item(bdpe_pkg::ACT_QUERY, 32'd1152, 4'h0, 2'd0);
        send_item(bdpe_pkg::ACT_SCAN, 32'd2000, 4'b1101, 2'd1);
        send_item(bdpe_pkg::ACT_SCAN, 32'd2051, 4'b1101, 2'd1);
        send_item(bdpe_pkg::ACT_SCAN, 32'd2060, 4'b1111, 2'd1);
        send_item(bdpe_pkg::ACT_SCAN, 32'd2111, 4'b1111, 2'd1);
        send_item(bdpe_pkg::ACT_QUERY, 32'd2112, 4'h0, 2'd1);
        send_item(bdpe_pkg::ACT_QUERY, 32'd2113, 4'h0, 2'd1);
        send_item(bdpe_pkg::ACT_SCAN, 32'hFFFF_FFF0, 4'b0000, 2'd2);
        send_item(bdpe_pkg::ACT_SCAN, 32'h0000_0030, 4'b0000, 2'd2);
        send_item(bdpe_pkg::ACT_QUERY, 32'h0000_0418, 4'hF, 2'd3);
        send_item(bdpe_pkg::ACT_QUERY, 32'hFFFF_FFFF, 4'hF, 2'd2);
        send_item(bdpe_pkg::ACT_QUERY, 32'hFFFF_FFFF, 4'hF, 2'd2);
        send_item(bdpe_pkg::ACT_SCAN, 32'hFFFF_FFFF, 4'b1111, 2'd0);
        send_item(bdpe_pkg::ACT_SCAN, 32'h0000_0040, 4'b1111, 2'd0);
        send_item(bdpe_pkg::ACT_QUERY, 32'h0000_0041, 4'h0, 2'd0);
        send_item(bdpe_pkg::ACT_QUERY, 32'h0000_0041, 4'h0, 2'd3);
        sim_ms = 32'h0000_0100;
        run_random(150);
        wait_for_results();

        load_config(16'd0, 16'd0);
        idle_on <= 1'b0;
        run_random(190);
        wait_for_results();

        load_config(16'hFFFF, 16'hFFFF);
        idle_on        <= 1'b1;
        long_stall_req <= 1'b1;
        run_random(190);
        wait_for_results();

        load_config(16'd3, 16'd40);
        run_random(190);
        wait_for_results();

        load_config(16'($urandom_range(1, 200)), 16'($urandom_range(1, 3000)));
        run_random(190);
        wait_for_results();

        load_config(bdpe_pkg::DEBOUNCE_RESET, bdpe_pkg::LONG_PRESS_RESET);
        run_random(190);
        wait_for_results();

        repeat (10) @(posedge aclk);
        sb.check_leftover();
        if (sb.mismatches == 0) begin
            $display("button_debounce_press_events_tb: done, clean");
        end else begin
            $display("button_debounce_press_events_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("button_debounce_press_events_tb: done, errors");
        $finish;
    end

endmodule
